/* src/key_request_byte_parser_macros.svh */
// Assertion helpers shared by the parser RTL.
`ifndef KEY_REQUEST_BYTE_PARSER_MACROS_SVH
`define KEY_REQUEST_BYTE_PARSER_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define KRBP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// A condition in one cycle that fixes what must hold in the next cycle.
`define KRBP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/krbp_pkg.sv */
package krbp_pkg;

  localparam int unsigned RAND_LEN_DEF = 16;
  localparam int unsigned RND_CNT_W = 8;
  localparam int unsigned BYTE_W = 8;
  localparam int unsigned LEN_W = 16;

  localparam logic [BYTE_W-1:0] CH_CREATE = 8'h63; // 'c'
  localparam logic [BYTE_W-1:0] CH_FIND   = 8'h66; // 'f'
  localparam logic [BYTE_W-1:0] CH_AUTH   = 8'h61; // 'a'
  localparam logic [BYTE_W-1:0] CH_VAR1   = 8'h31; // '1'
  localparam logic [BYTE_W-1:0] CH_VAR2   = 8'h32; // '2'

  typedef enum logic [2:0] {
    PH_METHOD1 = 3'd0,
    PH_METHOD2 = 3'd1,
    PH_RANDOM  = 3'd2,
    PH_LEN1    = 3'd3,
    PH_LEN2    = 3'd4,
    PH_DATA    = 3'd5
  } phase_e;

  typedef enum logic [1:0] {
    ST_MORE = 2'd0,
    ST_DONE = 2'd1,
    ST_BAD  = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    M_NONE   = 3'd0,
    M_CREATE = 3'd1,
    M_FIND   = 3'd2,
    M_AUTH   = 3'd3,
    M_AUTH1  = 3'd4,
    M_AUTH2  = 3'd5
  } method_e;

  typedef enum logic [1:0] {
    CL_NONE    = 2'd0,
    CL_RANDOM  = 2'd1,
    CL_PAYLOAD = 2'd2
  } class_e;

  typedef struct packed {
    phase_e                 phase;
    method_e                method;
    logic [BYTE_W-1:0]      len_lo;
    logic [LEN_W-1:0]       len;
    logic [LEN_W-1:0]       pay_cnt;
    logic [RND_CNT_W-1:0]   rnd_cnt;
  } state_t;

  typedef struct packed {
    status_e           status;
    method_e           method;
    class_e            cls;
    logic [BYTE_W-1:0] data;
    logic [LEN_W-1:0]  len;
  } result_t;

  localparam state_t STATE_RST = '{
    phase:   PH_METHOD1,
    method:  M_NONE,
    len_lo:  '0,
    len:     '0,
    pay_cnt: '0,
    rnd_cnt: '0
  };

endpackage

/* src/krbp_step.sv */
module krbp_step
  import krbp_pkg::*;
#(
  parameter int unsigned RandLen = RAND_LEN_DEF
) (
  input  state_t              state_i,
  input  logic                req_type_i,
  input  logic [BYTE_W-1:0]   in_byte_i,
  output state_t              state_o,
  output result_t             result_o
);

  localparam logic [RND_CNT_W-1:0] RandCnt = RND_CNT_W'(RandLen);

  logic [RND_CNT_W-1:0] rnd_next;
  logic [LEN_W-1:0]     pay_next;
  status_e              status;
  class_e               cls;
  logic [BYTE_W-1:0]    data;

  assign rnd_next = state_i.rnd_cnt + RND_CNT_W'(1);
  assign pay_next = state_i.pay_cnt + LEN_W'(1);

  always_comb begin
    state_o = state_i;
    status  = ST_MORE;
    cls     = CL_NONE;
    data    = '0;

    unique case (state_i.phase)
      PH_METHOD1: begin
        if (in_byte_i == CH_CREATE) begin
          state_o.method = M_CREATE;
          status         = ST_DONE;
        end else if (in_byte_i == CH_FIND) begin
          state_o.method = M_FIND;
          state_o.phase  = PH_METHOD2;
        end else if (in_byte_i == CH_AUTH) begin
          state_o.method = M_AUTH;
          state_o.phase  = PH_METHOD2;
        end else begin
          status = ST_BAD;
        end
      end
      PH_METHOD2: begin
        // A find request carries one ignored byte here.
        state_o.phase = PH_LEN1;
        if (state_i.method == M_AUTH) begin
          if (in_byte_i == CH_VAR1) begin
            state_o.method = M_AUTH1;
            state_o.phase  = PH_RANDOM;
          end else if (in_byte_i == CH_VAR2) begin
            state_o.method = M_AUTH2;
          end else begin
            status = ST_BAD;
          end
        end
      end
      PH_RANDOM: begin
        cls             = CL_RANDOM;
        data            = in_byte_i;
        state_o.rnd_cnt = rnd_next;
        if (rnd_next >= RandCnt) begin
          state_o.phase = PH_LEN1;
        end
      end
      PH_LEN1: begin
        state_o.len_lo = in_byte_i;
        state_o.phase  = PH_LEN2;
      end
      PH_LEN2: begin
        state_o.len   = {in_byte_i, state_i.len_lo};
        state_o.phase = PH_DATA;
      end
      PH_DATA: begin
        // Completion is flagged on the byte after the last payload byte.
        if (state_i.pay_cnt == state_i.len) begin
          status = ST_DONE;
        end else begin
          cls             = CL_PAYLOAD;
          data            = in_byte_i;
          state_o.pay_cnt = pay_next;
        end
      end
      default: begin
        status = ST_BAD;
      end
    endcase

    result_o.status = status;
    result_o.method = state_o.method;
    result_o.cls    = cls;
    result_o.data   = data;
    result_o.len    = state_o.len;

    if (req_type_i) begin
      state_o  = STATE_RST;
      result_o = '{status: ST_MORE, method: M_NONE, cls: CL_NONE, data: '0, len: '0};
    end
  end

endmodule

/* src/key_request_byte_parser.sv */
// Key request byte parser.
// Input channel: one item per handshake, either a request byte (req_type_i low)
// or a restart (req_type_i high) that returns the parser to its initial state.
// The first byte selects create, find or authenticate; authenticate variant 1
// then passes a fixed run of random bytes, and every method but create reads a
// little-endian 16-bit length followed by that many payload bytes.
// Output channel: exactly one result item per input item, carrying status,
// method, byte class, the passed byte and the declared payload length.
// A result is registered and is valid in the cycle after its item is taken.
// Throughput is one item per cycle while the receiver takes results; the parse
// state update and the result register are both written at the input handshake,
// so the limit is that single state register update.
// When the receiver stalls, the held result stays in the output register and
// in_ready_o drops until it is taken; the same cycle it is taken, a new item
// can be accepted. Reset clears the parse state and empties the output register.
module key_request_byte_parser
  import krbp_pkg::*;
#(
  parameter int unsigned RandLen = RAND_LEN_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic               req_type_i,
  input  logic [BYTE_W-1:0]  in_byte_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [1:0]         status_o,
  output logic [2:0]         method_code_o,
  output logic [1:0]         byte_class_o,
  output logic [BYTE_W-1:0]  out_byte_o,
  output logic [LEN_W-1:0]   payload_length_o
);

`include "key_request_byte_parser_macros.svh"

  state_t  state_q, state_d;
  result_t res_q, res_d;
  logic    out_valid_q;
  logic    in_acc;

  // The output register can take a new result whenever it is empty or
  // being drained in this same cycle.
  assign in_ready_o = !out_valid_q || out_ready_i;
  assign in_acc     = in_valid_i && in_ready_o;

  krbp_step #(
    .RandLen(RandLen)
  ) u_step (
    .state_i   (state_q),
    .req_type_i(req_type_i),
    .in_byte_i (in_byte_i),
    .state_o   (state_d),
    .result_o  (res_d)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= STATE_RST;
      out_valid_q <= 1'b0;
    end else begin
      if (in_acc) begin
        state_q <= state_d;
      end
      if (in_acc) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Result payload needs no reset; it is qualified by out_valid_q.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      res_q <= res_d;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign status_o         = res_q.status;
  assign method_code_o    = res_q.method;
  assign byte_class_o     = res_q.cls;
  assign out_byte_o       = res_q.data;
  assign payload_length_o = res_q.len;

  `KRBP_ASSERT(a_pay_le_len, state_q.pay_cnt <= state_q.len,
               "payload count ran past the declared length")
  `KRBP_ASSERT(a_rnd_auth1, !(out_valid_q && res_q.cls == CL_RANDOM) ||
               res_q.method == M_AUTH1, "random byte outside variant 1")
  `KRBP_ASSERT(a_done_nobyte, !(out_valid_q && res_q.status == ST_DONE) ||
               res_q.cls == CL_NONE, "completion reported together with a byte")
  `KRBP_ASSERT_NEXT(a_restart, in_acc && req_type_i,
                    state_q.phase == PH_METHOD1 && state_q.method == M_NONE &&
                    out_valid_q, "restart did not clear the parser")

endmodule

/* verif/key_request_byte_parser_test.sv */
`timescale 1ns / 1ps

// Self-checking bench for the key request byte parser.
// A behavioral parser in this module tracks the request state and works out
// the result of every item at the moment the block accepts it. A separate
// process compares each result that leaves the block, field by field, with
// the oldest result still waiting.
module key_request_byte_parser_test;
  import krbp_pkg::*;

  localparam int unsigned RAND_RUN    = RAND_LEN_DEF;
  localparam int unsigned CYCLE_LIMIT = 200_000;
  localparam int unsigned HOLD_CYCLES = 120;
  localparam int unsigned MAX_REPORTS = 30;
  localparam int unsigned IDLE_PCT    = 36;

  // One input item as the sender sees it.
  typedef struct packed {
    logic              restart;
    logic [BYTE_W-1:0] data;
  } req_item_t;

  logic              clk_i = 1'b0;
  logic              rst_ni = 1'b0;
  logic              in_valid_i = 1'b0;
  logic              in_ready_o;
  logic              req_type_i = 1'b0;
  logic [BYTE_W-1:0] in_byte_i = '0;
  logic              out_valid_o;
  logic              out_ready_i = 1'b0;
  logic [1:0]        status_o;
  logic [2:0]        method_code_o;
  logic [1:0]        byte_class_o;
  logic [BYTE_W-1:0] out_byte_o;
  logic [LEN_W-1:0]  payload_length_o;

  // Idling controls for both sides and the request for one long output stall.
  bit                send_idle_on = 1'b1;
  logic              recv_idle_on = 1'b1;
  logic              stall_ask = 1'b0;
  int unsigned       hold_left = 0;

  // Parser state as the bench believes it, and the results still to come.
  state_t            parser_state = STATE_RST;
  result_t           pending_results[$];
  result_t           next_want;

  int unsigned       items_sent = 0;
  int unsigned       results_seen = 0;
  int unsigned       mismatch_count = 0;
  int unsigned       cycle_count = 0;

  key_request_byte_parser #(
    .RandLen(RAND_RUN)
  ) DUT (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .req_type_i      (req_type_i),
    .in_byte_i       (in_byte_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .status_o        (status_o),
    .method_code_o   (method_code_o),
    .byte_class_o    (byte_class_o),
    .out_byte_o      (out_byte_o),
    .payload_length_o(payload_length_o)
  );

  always #5 clk_i = ~clk_i;

  // Advances the tracked parser state by one item and returns the result that
  // item must produce. The method and length fields show the state after the
  // update, as the block reports them.
  function automatic result_t parse_request_byte(input logic restart,
                                                 input logic [BYTE_W-1:0] data);
    result_t res;
    res = '0;
    res.status = ST_MORE;
    res.method = M_NONE;
    res.cls    = CL_NONE;
    if (restart) begin
      // A restart stands for a fresh request: all state clears and the
      // result carries nothing.
      parser_state = STATE_RST;
      return res;
    end
    case (parser_state.phase)
      PH_METHOD1: begin
        if (data == CH_CREATE) begin
          // Create completes at once and leaves the parser waiting for a
          // new method byte.
          parser_state.method = M_CREATE;
          res.status = ST_DONE;
        end else if (data == CH_FIND) begin
          parser_state.method = M_FIND;
          parser_state.phase  = PH_METHOD2;
        end else if (data == CH_AUTH) begin
          parser_state.method = M_AUTH;
          parser_state.phase  = PH_METHOD2;
        end else begin
          res.status = ST_BAD;
        end
      end
      PH_METHOD2: begin
        // Find ignores its second byte. An unknown variant is flagged but
        // the parser still goes on to the length.
        parser_state.phase = PH_LEN1;
        if (parser_state.method == M_AUTH) begin
          if (data == CH_VAR1) begin
            parser_state.method = M_AUTH1;
            parser_state.phase  = PH_RANDOM;
          end else if (data == CH_VAR2) begin
            parser_state.method = M_AUTH2;
          end else begin
            res.status = ST_BAD;
          end
        end
      end
      PH_RANDOM: begin
        res.cls  = CL_RANDOM;
        res.data = data;
        parser_state.rnd_cnt = parser_state.rnd_cnt + 1'b1;
        if (parser_state.rnd_cnt >= RND_CNT_W'(RAND_RUN)) begin
          parser_state.phase = PH_LEN1;
        end
      end
      PH_LEN1: begin
        parser_state.len_lo = data;
        parser_state.phase  = PH_LEN2;
      end
      PH_LEN2: begin
        parser_state.len   = {data, parser_state.len_lo};
        parser_state.phase = PH_DATA;
      end
      PH_DATA: begin
        // Once the declared count is reached, every further byte reports
        // completion and is dropped.
        if (parser_state.pay_cnt == parser_state.len) begin
          res.status = ST_DONE;
        end else begin
          res.cls  = CL_PAYLOAD;
          res.data = data;
          parser_state.pay_cnt = parser_state.pay_cnt + 1'b1;
        end
      end
      default: begin
        res.status = ST_BAD;
      end
    endcase
    res.method = parser_state.method;
    res.len    = parser_state.len;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [LEN_W-1:0] got,
                                 input logic [LEN_W-1:0] want);
    mismatch_count++;
    if (mismatch_count <= MAX_REPORTS) begin
      $display("mismatch at result %0d: %s got %h want %h", results_seen, what, got,
               want);
    end
  endtask

  // Offers one item and holds it until the block takes it. The prediction is
  // made at the accepting edge, so it follows the order of acceptance.
  task automatic send_item(input logic restart, input logic [BYTE_W-1:0] data);
    while (send_idle_on && $urandom_range(99) < IDLE_PCT) begin
      in_valid_i <= 1'b0;
      in_byte_i  <= BYTE_W'($urandom);
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    req_type_i <= restart;
    in_byte_i  <= data;
    do @(posedge clk_i); while (in_ready_o !== 1'b1);
    pending_results = {pending_results, parse_request_byte(restart, data)};
    items_sent++;
  endtask

  // Method bytes: unknown ones, create twice in a row, and a find request
  // with an empty payload followed by more bytes after completion.
  task automatic test_method_bytes();
    send_item(1'b1, 8'h00);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hFF);
    send_item(1'b0, CH_CREATE);
    send_item(1'b0, CH_CREATE);
    send_item(1'b0, CH_FIND);
    send_item(1'b0, 8'hFF);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'h77);
    send_item(1'b0, 8'h88);
  endtask

  // Authenticate: an unknown variant with the largest length cut short by a
  // restart, then variant 2 with a one byte payload run to completion.
  task automatic test_auth_variants();
    send_item(1'b1, 8'hA5);
    send_item(1'b0, CH_AUTH);
    send_item(1'b0, 8'h37);
    send_item(1'b0, 8'hFF);
    send_item(1'b0, 8'hFF);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'hFF);
    send_item(1'b1, 8'h5A);
    send_item(1'b0, CH_AUTH);
    send_item(1'b0, CH_VAR2);
    send_item(1'b0, 8'h01);
    send_item(1'b0, 8'h00);
    send_item(1'b0, 8'h5A);
    send_item(1'b0, 8'h00);
    send_item(1'b1, 8'hFF);
  endtask

  // Mostly well-formed requests with random content, each opened by a
  // restart; the rest is noise. Some requests are cut off part way.
  task automatic test_random_requests(input int unsigned n_items);
    req_item_t   seq[$];
    int unsigned stop_at;
    int unsigned len;
    int unsigned n_pay;
    int unsigned cut;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      seq.delete();
      if ($urandom_range(99) < 15) begin
        repeat ($urandom_range(1, 6)) begin
          seq = {seq, req_item_t'{restart: ($urandom_range(9) == 0),
                                  data: BYTE_W'($urandom)}};
        end
      end else begin
        seq = {seq, req_item_t'{restart: 1'b1, data: BYTE_W'($urandom)}};
        case ($urandom_range(4))
          0: seq = {seq, req_item_t'{restart: 1'b0, data: CH_CREATE}};
          1: begin
            seq = {seq, req_item_t'{restart: 1'b0, data: CH_FIND}};
            seq = {seq, req_item_t'{restart: 1'b0, data: BYTE_W'($urandom)}};
          end
          2: begin
            seq = {seq, req_item_t'{restart: 1'b0, data: CH_AUTH}};
            seq = {seq, req_item_t'{restart: 1'b0, data: CH_VAR1}};
            repeat (RAND_RUN) seq = {seq, req_item_t'{restart: 1'b0, data: BYTE_W'($urandom)}};
          end
          3: begin
            seq = {seq, req_item_t'{restart: 1'b0, data: CH_AUTH}};
            seq = {seq, req_item_t'{restart: 1'b0, data: CH_VAR2}};
          end
          default: begin
            seq = {seq, req_item_t'{restart: 1'b0, data: CH_AUTH}};
            seq = {seq, req_item_t'{restart: 1'b0, data: BYTE_W'($urandom)}};
          end
        endcase
        if (seq[1].data != CH_CREATE) begin
          // Long declared lengths are never run out; the next request's
          // restart cuts them short.
          len = ($urandom_range(9) == 0) ? $urandom_range(16'hFFFF) : $urandom_range(0, 6);
          seq = {seq, req_item_t'{restart: 1'b0, data: len[7:0]}};
          seq = {seq, req_item_t'{restart: 1'b0, data: len[15:8]}};
          n_pay = (len > 8) ? 8 : len;
          repeat (n_pay) seq = {seq, req_item_t'{restart: 1'b0, data: BYTE_W'($urandom)}};
          if (n_pay == len) begin
            repeat ($urandom_range(1, 2)) begin
              seq = {seq, req_item_t'{restart: 1'b0, data: BYTE_W'($urandom)}};
            end
          end
        end
        if (seq.size() > 2 && $urandom_range(9) == 0) begin
          cut = $urandom_range(1, seq.size() - 1);
          while (seq.size() > cut) void'(seq.pop_back());
        end
      end
      foreach (seq[i]) send_item(seq[i].restart, seq[i].data);
    end
  endtask

  // The receiver stops for a long stretch while requests keep coming, so the
  // held result blocks the input.
  task automatic test_output_stall();
    send_idle_on = 1'b0;
    stall_ask <= 1'b1;
    test_random_requests(80);
    send_idle_on = 1'b1;
  endtask

  // Receiver side: random readiness, a stretch of constant readiness, and
  // the one long hold-off counted here.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_left != 0) begin
      out_ready_i <= 1'b0;
      hold_left   <= hold_left - 1;
    end else if (stall_ask) begin
      stall_ask   <= 1'b0;
      hold_left   <= HOLD_CYCLES;
      out_ready_i <= 1'b0;
    end else if (recv_idle_on) begin
      out_ready_i <= ($urandom_range(99) >= IDLE_PCT);
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // Result checker. Values are taken at the edge, before any update that the
  // edge itself causes.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && out_ready_i) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing expected", LEN_W'(status_o), '0);
      end else begin
        next_want = pending_results.pop_front();
        if (status_o !== next_want.status) begin
          report_mismatch("status", LEN_W'(status_o), LEN_W'(next_want.status));
        end
        if (method_code_o !== next_want.method) begin
          report_mismatch("method", LEN_W'(method_code_o), LEN_W'(next_want.method));
        end
        if (byte_class_o !== next_want.cls) begin
          report_mismatch("byte class", LEN_W'(byte_class_o), LEN_W'(next_want.cls));
        end
        if (out_byte_o !== next_want.data) begin
          report_mismatch("byte", LEN_W'(out_byte_o), LEN_W'(next_want.data));
        end
        if (payload_length_o !== next_want.len) begin
          report_mismatch("length", payload_length_o, next_want.len);
        end
      end
    end
  end

  // Watchdog for a block that hangs.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_method_bytes();
    test_auth_variants();
    test_random_requests(850);

    // A long stretch with both sides always willing.
    send_idle_on = 1'b0;
    recv_idle_on <= 1'b0;
    test_random_requests(220);
    send_idle_on = 1'b1;
    recv_idle_on <= 1'b1;

    test_output_stall();
    in_valid_i <= 1'b0;

    // Drain, then wait for any stray result to show up.
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);

    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
